// ===== src/rft_pkg.sv =====
package rft_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int RAILS_W     = 7;
  localparam logic [RAILS_W-1:0] RAILS_RESET = 7'd2;
  localparam logic [RAILS_W-1:0] RAILS_MIN   = 7'd2;

  typedef enum logic [0:0] {
    REG_RAILS = 1'b0,
    REG_DIR   = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_ENC,
    S_PERM,
    S_GAP,
    S_DEC
  } rft_state_t;

  typedef struct packed {
    logic start;
    logic step;
  } og_ctl_t;

endpackage

// ===== src/rail_fence_transposer.sv =====
// Rail fence transposer. Message bytes stream in one per cycle into a
// MAX_LEN-byte store until the beat with in_last. The block then stops
// taking input and emits the whole message as one burst, one byte per
// cycle while out_ready is high: in encrypt mode (direction 0) rail by
// rail, in decrypt mode (direction 1) in plaintext order. Decrypt first
// scatters the store into a second memory at one byte per cycle, once
// no stalled beat of the previous burst holds the store's read data, and
// its read-out burst starts once the scatter is done. The single read port
// of each memory sets the one byte per cycle. Bytes beyond MAX_LEN are
// dropped and out_overflow is then high on every beat of that burst.
// The rails and direction values at the last beat are used; rails below
// two act as two.
module rail_fence_transposer #(
  parameter int MAX_LEN = rft_pkg::MAX_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_byte,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic                        out_last,
  output logic                        out_overflow,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_index,
  input  logic [rft_pkg::RAILS_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  rft_pkg::rft_state_t state_r, state_nxt;

  logic [rft_pkg::RAILS_W-1:0] rails_r;
  logic                        direction_r;
  logic [CW-1:0]               fill_r;
  logic                        drop_r;
  logic [CW-1:0]               n_r;
  logic [rft_pkg::RAILS_W-1:0] nr_r;
  logic                        ovf_r;
  logic [AW-1:0]               ctr_r, ctr_nxt;

  logic [7:0] mem_a [MAX_LEN];
  logic [7:0] mem_b [MAX_LEN];
  logic [7:0] a_rdata_r;
  logic [7:0] b_rdata_r;

  logic          wb_v_r, wb_v_nxt;
  logic [AW-1:0] wb_addr_r;

  logic rd_v_r, rd_last_r, rd_ovf_r, rd_src_r;
  logic out_v_r, out_last_r, out_ovf_r;
  logic [7:0] out_byte_r;

  rft_pkg::og_ctl_t og_ctl;
  logic [AW-1:0]    og_pos;

  logic          in_acc;
  logic          full;
  logic          a_we;
  logic          a_re;
  logic [AW-1:0] a_raddr;
  logic          b_re;
  logic          issue;
  logic          adv;
  logic          burst_end;
  logic          ready_c;
  logic [CW-1:0] n_load;
  logic [rft_pkg::RAILS_W-1:0] nr_sel;

  rft_order_gen #(.MAX_LEN(MAX_LEN)) u_order (
    .clk (clk),
    .ctl (og_ctl),
    .nr  (nr_r),
    .n   (n_r),
    .pos (og_pos)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = ready_c;
  assign in_acc    = in_valid && ready_c;
  assign full      = (fill_r == CW'(MAX_LEN));
  assign a_we      = in_acc && !full;
  assign n_load    = full ? fill_r : fill_r + CW'(1);
  assign nr_sel    = (rails_r < rft_pkg::RAILS_MIN) ? rft_pkg::RAILS_MIN : rails_r;
  assign adv       = !out_v_r || out_ready;
  assign burst_end = (CW'(ctr_r) == n_r - CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rails_r     <= rft_pkg::RAILS_RESET;
      direction_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rft_pkg::REG_RAILS: rails_r     <= cfg_data;
        rft_pkg::REG_DIR:   direction_r <= cfg_data[0];
        default:            rails_r     <= rails_r;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctr_nxt   = ctr_r;
    og_ctl    = '0;
    a_re      = 1'b0;
    a_raddr   = ctr_r;
    b_re      = 1'b0;
    issue     = 1'b0;
    wb_v_nxt  = 1'b0;
    ready_c   = 1'b0;
    unique case (state_r)
      rft_pkg::S_LOAD: begin
        ready_c = 1'b1;
        if (in_valid && in_last) begin
          og_ctl.start = 1'b1;
          ctr_nxt      = '0;
          state_nxt    = direction_r ? rft_pkg::S_PERM : rft_pkg::S_ENC;
        end
      end
      rft_pkg::S_ENC: begin
        if (!rd_v_r || adv) begin
          issue       = 1'b1;
          a_re        = 1'b1;
          a_raddr     = og_pos;
          og_ctl.step = 1'b1;
          ctr_nxt     = ctr_r + AW'(1);
          if (burst_end) state_nxt = rft_pkg::S_LOAD;
        end
      end
      rft_pkg::S_PERM: begin
        // wait until a stalled beat no longer holds the store's read data
        if (!rd_v_r) begin
          a_re        = 1'b1;
          wb_v_nxt    = 1'b1;
          og_ctl.step = 1'b1;
          ctr_nxt     = ctr_r + AW'(1);
          if (burst_end) begin
            ctr_nxt   = '0;
            state_nxt = rft_pkg::S_GAP;
          end
        end
      end
      rft_pkg::S_GAP: begin
        state_nxt = rft_pkg::S_DEC;
      end
      rft_pkg::S_DEC: begin
        if (!rd_v_r || adv) begin
          issue   = 1'b1;
          b_re    = 1'b1;
          ctr_nxt = ctr_r + AW'(1);
          if (burst_end) state_nxt = rft_pkg::S_LOAD;
        end
      end
      default: state_nxt = rft_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rft_pkg::S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      drop_r <= 1'b0;
      wb_v_r <= 1'b0;
      rd_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_last) begin
          fill_r <= '0;
          drop_r <= 1'b0;
        end else if (full) begin
          drop_r <= 1'b1;
        end else begin
          fill_r <= fill_r + CW'(1);
        end
      end
      wb_v_r  <= wb_v_nxt;
      rd_v_r  <= issue || (rd_v_r && !adv);
      if (adv) out_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    ctr_r <= ctr_nxt;
    if (in_acc && in_last) begin
      n_r   <= n_load;
      nr_r  <= nr_sel;
      ovf_r <= drop_r || full;
    end
    if (wb_v_nxt) wb_addr_r <= og_pos;
    if (issue) begin
      rd_last_r <= burst_end;
      rd_ovf_r  <= ovf_r;
      rd_src_r  <= (state_r == rft_pkg::S_DEC);
    end
    if (adv && rd_v_r) begin
      out_byte_r <= rd_src_r ? b_rdata_r : a_rdata_r;
      out_last_r <= rd_last_r;
      out_ovf_r  <= rd_ovf_r;
    end
  end

  // message store
  always_ff @(posedge clk) begin
    if (a_we) mem_a[fill_r[AW-1:0]] <= in_byte;
    if (a_re) a_rdata_r <= mem_a[a_raddr];
  end

  // plaintext store for decrypt
  always_ff @(posedge clk) begin
    if (wb_v_r) mem_b[wb_addr_r] <= a_rdata_r;
    if (b_re) b_rdata_r <= mem_b[ctr_r];
  end

  assign out_valid    = out_v_r;
  assign out_byte     = out_byte_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

  a_enc_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rft_pkg::S_ENC && issue) |-> (CW'(og_pos) < n_r))
    else $error("rail order position beyond message length");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(MAX_LEN))
    else $error("fill count beyond store depth");

  a_scatter_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rft_pkg::S_DEC) |-> !wb_v_r)
    else $error("plaintext store written while being read out");

  a_store_port: assert property (@(posedge clk) disable iff (!rst_n)
    a_re |-> !a_we)
    else $error("store read and written in the same cycle");

endmodule

// ===== src/rft_order_gen.sv =====
module rft_order_gen #(
  parameter int MAX_LEN = rft_pkg::MAX_LEN_DEF,
  localparam int AW = $clog2(MAX_LEN),
  localparam int CW = $clog2(MAX_LEN + 1)
) (
  input  logic                         clk,
  input  rft_pkg::og_ctl_t             ctl,
  input  logic [rft_pkg::RAILS_W-1:0]  nr,
  input  logic [CW-1:0]                n,
  output logic [AW-1:0]                pos
);

  localparam int SW = ((AW > 8) ? AW : 8) + 1;

  logic [AW-1:0]               pos_r;
  logic [rft_pkg::RAILS_W-1:0] rail_r;
  logic                        phase_r;

  logic [7:0]                  period;
  logic [7:0]                  twice;
  logic [7:0]                  stride;
  logic                        rail_edge;
  logic [SW-1:0]               sum;
  logic                        in_rail;
  logic [rft_pkg::RAILS_W-1:0] rail_inc;

  // zigzag walk: rails in order, positions in order within a rail
  always_comb begin
    period    = {nr - 7'd1, 1'b0};
    twice     = {rail_r, 1'b0};
    rail_edge = (rail_r == '0) || (rail_r == nr - 7'd1);
    stride    = rail_edge ? period : (phase_r ? twice : period - twice);
    sum       = SW'(pos_r) + SW'(stride);
    in_rail   = sum < SW'(n);
    rail_inc  = rail_r + 7'd1;
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      pos_r   <= '0;
      rail_r  <= '0;
      phase_r <= 1'b0;
    end else if (ctl.step) begin
      if (in_rail) begin
        pos_r   <= sum[AW-1:0];
        phase_r <= ~phase_r;
      end else begin
        pos_r   <= AW'(rail_inc);
        rail_r  <= rail_inc;
        phase_r <= 1'b0;
      end
    end
  end

  assign pos = pos_r;

endmodule

// ===== test/tb_rail_fence_transposer.sv =====
module tb_rail_fence_transposer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN      = rft_pkg::MAX_LEN_DEF;
  localparam int DRAIN_CYCLES = MAX_LEN + 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int RAND_BYTES   = 170;
  localparam int CALM_AFTER   = 150;
  localparam int HOLD_AT_BEAT = 40;
  localparam int HOLD_CYCLES  = 160;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } cipher_beat_t;

  typedef enum logic [0:0] {
    ROW_BYTE,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    rft_pkg::cfg_reg_t idx;
    logic [7:0]        data;
    logic              last;
    logic              typed;
    cipher_beat_t      want;
  } stim_row_t;

  localparam cipher_beat_t NONE = '0;
  localparam int SCRIPT_LEN = 35;

  // directed stimulus: register writes and message bytes
  stim_row_t script [SCRIPT_LEN] = '{
    // reset key, single-byte messages at both byte extremes, then a five-byte message
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'hff, 1'b1, 1'b1, '{8'hff, 1'b1, 1'b0}},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h41, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h42, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h43, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h44, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h45, 1'b1, 1'b0, NONE},
    // three rails, decrypt
    '{ROW_REG,  rft_pkg::REG_RAILS, 8'h03, 1'b0, 1'b0, NONE},
    '{ROW_REG,  rft_pkg::REG_DIR,   8'h01, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h5a, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'ha5, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h3c, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'hc3, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h81, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h7e, 1'b1, 1'b0, NONE},
    // rails of zero and one behave as two
    '{ROW_REG,  rft_pkg::REG_RAILS, 8'h00, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h10, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h20, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h30, 1'b1, 1'b0, NONE},
    '{ROW_REG,  rft_pkg::REG_RAILS, 8'h01, 1'b0, 1'b0, NONE},
    '{ROW_REG,  rft_pkg::REG_DIR,   8'h00, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h01, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h02, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h03, 1'b1, 1'b0, NONE},
    // rails beyond the store size
    '{ROW_REG,  rft_pkg::REG_RAILS, 8'h7f, 1'b0, 1'b0, NONE},
    '{ROW_REG,  rft_pkg::REG_DIR,   8'h01, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h0f, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'hf0, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h55, 1'b1, 1'b0, NONE},
    // key changes while a message is half loaded
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'haa, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'hcc, 1'b0, 1'b0, NONE},
    '{ROW_REG,  rft_pkg::REG_RAILS, 8'h40, 1'b0, 1'b0, NONE},
    '{ROW_REG,  rft_pkg::REG_DIR,   8'h00, 1'b0, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h33, 1'b1, 1'b0, NONE},
    '{ROW_BYTE, rft_pkg::REG_RAILS, 8'h99, 1'b1, 1'b1, '{8'h99, 1'b1, 1'b0}}
  };

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_ready;
  logic [7:0]       in_byte      = 8'h00;
  logic             in_last      = 1'b0;
  logic             out_valid;
  logic             out_ready    = 1'b0;
  logic [7:0]       out_byte;
  logic             out_last;
  logic             out_overflow;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  logic [0:0]       cfg_index    = rft_pkg::REG_RAILS;
  logic [rft_pkg::RAILS_W-1:0] cfg_data = '0;

  // predictor state
  logic [7:0]                  msg_buf [MAX_LEN];
  int unsigned                 msg_len     = 0;
  logic                        msg_dropped = 1'b0;
  logic [rft_pkg::RAILS_W-1:0] key_rails   = rft_pkg::RAILS_RESET;
  logic                        key_dir     = 1'b0;

  cipher_beat_t fresh_beats[$];
  cipher_beat_t awaited_beats[$];
  cipher_beat_t head;

  int  errors       = 0;
  int  bytes_sent   = 0;
  int  msgs_closed  = 0;
  int  reg_writes   = 0;
  int  beats_seen   = 0;
  int  ovf_beats    = 0;
  int  idle_cycles  = 0;
  int  stall_left   = 0;
  int  run_left     = 0;
  int  hold_left    = 0;
  bit  held_once    = 1'b0;
  bit  calm         = 1'b0;

  rail_fence_transposer dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_overflow (out_overflow),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // load one byte; on the last byte compute the whole permuted burst
  function automatic void rail_fence_step(input logic [7:0] b, input logic l);
    int unsigned nr, per, m, r, i, k, n, rail;
    int unsigned order [MAX_LEN];
    logic [7:0]  plain [MAX_LEN];
    cipher_beat_t beat;
    if (msg_len < MAX_LEN) begin
      msg_buf[msg_len] = b;
      msg_len++;
    end else begin
      msg_dropped = 1'b1;
    end
    if (!l) return;
    n   = msg_len;
    nr  = (key_rails < rft_pkg::RAILS_MIN) ? 2 : key_rails;
    per = 2 * (nr - 1);
    k   = 0;
    for (r = 0; r < nr && k < n; r++) begin
      for (i = 0; i < n; i++) begin
        m    = i % per;
        rail = (m < nr - 1) ? m : per - m;
        if (rail == r) begin
          order[k] = i;
          k++;
        end
      end
    end
    for (k = 0; k < n; k++) plain[order[k]] = msg_buf[k];
    for (k = 0; k < n; k++) begin
      beat.data = key_dir ? plain[k] : msg_buf[order[k]];
      beat.last = (k + 1 == n);
      beat.ovf  = msg_dropped;
      fresh_beats.push_back(beat);
    end
    msg_len     = 0;
    msg_dropped = 1'b0;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                           input cipher_beat_t want);
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (l) msgs_closed++;
    rail_fence_step(b, l);
    if (typed) begin
      fresh_beats.delete();
      awaited_beats.push_back(want);
    end else begin
      while (fresh_beats.size() != 0) awaited_beats.push_back(fresh_beats.pop_front());
    end
  endtask

  task automatic write_reg(input rft_pkg::cfg_reg_t idx,
                           input logic [rft_pkg::RAILS_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    if (idx == rft_pkg::REG_RAILS) key_rails = d;
    else key_dir = d[0];
  endtask

  // stop offering bytes, let the burst drain, then give the block time to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: random ready, one long hold-off, beat checking
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        beats_seen++;
        if (out_last && out_overflow) ovf_beats++;
        if (awaited_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat byte %02h last %0b overflow %0b",
                   $time, out_byte, out_last, out_overflow);
        end else begin
          head = awaited_beats.pop_front();
          if (out_byte !== head.data) begin
            errors++;
            $display("%0t: out_byte expected %02h got %02h", $time, head.data, out_byte);
          end
          if (out_last !== head.last) begin
            errors++;
            $display("%0t: out_last expected %0b got %0b", $time, head.last, out_last);
          end
          if (out_overflow !== head.ovf) begin
            errors++;
            $display("%0t: out_overflow expected %0b got %0b",
                     $time, head.ovf, out_overflow);
          end
        end
      end
      if (!held_once && beats_seen >= HOLD_AT_BEAT) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else if (!calm) begin
          stall_left = $urandom_range(1, 6);
          run_left   = $urandom_range(0, 20);
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("tb_rail_fence_transposer: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned  rand_bytes;
    int unsigned  phase;
    int unsigned  n_msgs;
    int unsigned  len;
    int unsigned  mi;
    int unsigned  bi;
    bit           split;
    bit           quiet;
    logic         l;
    logic [rft_pkg::RAILS_W-1:0] r;
    rand_bytes = 0;
    phase      = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[j]) begin
      if (script[j].kind == ROW_REG) begin
        wait_idle();
        write_reg(script[j].idx, script[j].data[rft_pkg::RAILS_W-1:0]);
      end else begin
        send_byte(script[j].data, script[j].last, script[j].typed, script[j].want);
      end
    end

    while (rand_bytes < RAND_BYTES) begin
      case ($urandom_range(0, 7))
        0:       r = rft_pkg::RAILS_W'($urandom_range(0, 1));
        1:       r = rft_pkg::RAILS_W'($urandom_range(65, 127));
        2:       r = 7'd64;
        default: r = rft_pkg::RAILS_W'($urandom_range(2, 8));
      endcase
      wait_idle();
      write_reg(rft_pkg::REG_RAILS, r);
      wait_idle();
      write_reg(rft_pkg::REG_DIR, rft_pkg::RAILS_W'($urandom_range(0, 1)));
      quiet  = (phase % 3 == 2);
      n_msgs = (phase == 0) ? 3 : $urandom_range(1, 4);
      for (mi = 0; mi < n_msgs; mi++) begin
        // one message that exactly fills the store, one that runs past it
        if (phase == 0 && mi == 0) len = MAX_LEN;
        else if (phase == 1 && mi == 0) len = MAX_LEN + 2;
        else if ($urandom_range(0, 9) == 0) len = $urandom_range(13, 40);
        else len = $urandom_range(1, 10);
        split = (mi == n_msgs - 1) && ($urandom_range(0, 4) == 0);
        for (bi = 0; bi < len; bi++) begin
          l = (bi == len - 1) && !split;
          if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
          end
          send_byte(8'($urandom_range(0, 255)), l, 1'b0, NONE);
          rand_bytes++;
          calm = (rand_bytes >= CALM_AFTER);
        end
      end
      phase++;
    end

    // close a message left open
    if (msg_len != 0 || msg_dropped) send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, NONE);
    wait_idle();

    $display("%0d bytes in %0d messages under %0d register writes", bytes_sent, msgs_closed,
             reg_writes);
    $display("%0d output beats checked, %0d bursts flagged overflow", beats_seen, ovf_beats);
    if (errors == 0) begin
      $display("tb_rail_fence_transposer: clean");
    end else begin
      $display("tb_rail_fence_transposer: errors");
    end
    $finish;
  end

endmodule
